// ===== sv/sli_pkg.sv =====
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;   // register compare flags against the key
        logic ins;   // open a slot and write the key
        logic del;   // close the slot at the first match
    } t_cell_ctl;

endpackage

// ===== sv/sli_in_if.sv =====
interface sli_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [sli_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== sv/sli_out_if.sv =====
interface sli_out_if;
    logic                                valid;
    logic                                ready;
    logic        [sli_pkg::STATUS_W-1:0] status;
    logic        [sli_pkg::COUNT_W-1:0]  entry_count;
    logic                                smallest_valid;
    logic signed [sli_pkg::VALUE_W-1:0]  smallest_value;

    modport source (output valid, output status, output entry_count,
                    output smallest_valid, output smallest_value, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input smallest_valid, input smallest_value, output ready);
endinterface

// ===== sv/sli_cell.sv =====
module sli_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sli_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_key,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_left_val,
    input  logic                               i_left_valid,
    input  logic                               i_left_lt_or_head,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_right_val,
    input  logic                               i_right_valid,
    output logic signed [sli_pkg::VALUE_W-1:0] o_val,
    output logic                               o_valid,
    output logic                               o_lt,
    output logic                               o_hit
);

    logic signed [sli_pkg::VALUE_W-1:0] r_val;
    logic                               r_valid;
    logic                               r_lt;
    logic                               r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && !r_lt) begin
            r_valid <= r_valid | i_left_valid;
        end else if (i_ctl.del && !r_lt) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            // first slot at or above the key takes it, the rest shift right
            r_val <= i_left_lt_or_head ? i_key : i_left_val;
        end else if (i_ctl.del && !r_lt) begin
            r_val <= i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= r_valid && (r_val < i_key);
            r_eq <= r_valid && (r_val == i_key);
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_hit   = r_eq & i_left_lt_or_head;

endmodule

// ===== sv/sorted_list_insert_delete.sv =====
// Sorted store of up to CAPACITY signed 32-bit values held in a row of
// compare-and-shift cells, ascending from cell 0. An insert item goes ahead
// of any equal entries; into a full store it is dropped with status 1. A
// delete item removes the first entry exactly equal to its value, or reports
// status 2 when there is none. Every item yields one result item with the
// status, the entry count after the item (low 5 bits) and the smallest
// stored value (zero when empty). Each item passes through the states accept,
// compare, in which every cell compares itself against the key, shift, in
// which the cells shift toward or away from the chosen slot, and output, which
// loads the output register once it is free. A new item is accepted right after the
// result is loaded, while that result may still wait at the output.
module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sli_in_if.sink     i_in,
    sli_out_if.source  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                                r_state, n_state;
    logic                                  r_op;
    logic signed [sli_pkg::VALUE_W-1:0]    r_key;
    logic        [CNT_W-1:0]               r_count;
    logic        [sli_pkg::STATUS_W-1:0]   r_status;

    logic                                  r_out_valid;
    logic        [sli_pkg::STATUS_W-1:0]   r_out_status;
    logic        [sli_pkg::COUNT_W-1:0]    r_out_count;
    logic                                  r_out_sm_valid;
    logic signed [sli_pkg::VALUE_W-1:0]    r_out_sm_value;

    sli_pkg::t_cell_ctl                    w_ctl;
    logic signed [sli_pkg::VALUE_W-1:0]    w_val [CAPACITY];
    logic        [CAPACITY-1:0]            w_valid;
    logic        [CAPACITY-1:0]            w_lt;
    logic        [CAPACITY-1:0]            w_hit;
    logic                                  w_found;
    logic                                  w_full;
    logic                                  w_in_take;
    logic                                  w_out_free;
    logic        [CNT_W+sli_pkg::COUNT_W-1:0] w_count_ext;

    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // At most one cell can hold the first match; any hit means found
    assign w_found = |w_hit;
    assign w_full  = w_valid[CAPACITY-1];

    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = (r_state == S_UPD) && (r_op == sli_pkg::OP_INSERT) && !w_full;
        w_ctl.del = (r_state == S_UPD) && (r_op == sli_pkg::OP_DELETE) && w_found;
    end

    // Cell row: each cell sees its left and right neighbor only
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [sli_pkg::VALUE_W-1:0] w_lval, w_rval;
        logic                               w_lvalid, w_llt, w_rvalid;

        if (i == 0) begin : g_head
            assign w_lval   = r_key;
            assign w_lvalid = 1'b1;
            assign w_llt    = 1'b1;
        end else begin : g_body
            assign w_lval   = w_val[i-1];
            assign w_lvalid = w_valid[i-1];
            assign w_llt    = w_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_rval   = r_key;
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rval   = w_val[i+1];
            assign w_rvalid = w_valid[i+1];
        end

        sli_cell u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctl             (w_ctl),
            .i_key             (r_key),
            .i_left_val        (w_lval),
            .i_left_valid      (w_lvalid),
            .i_left_lt_or_head (w_llt),
            .i_right_val       (w_rval),
            .i_right_valid     (w_rvalid),
            .o_val             (w_val[i]),
            .o_valid           (w_valid[i]),
            .o_lt              (w_lt[i]),
            .o_hit             (w_hit[i])
        );
    end

    // Sequencer: accept, compare, shift, load result
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_take) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctl.del) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Latch the item and the status it earns
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op  <= i_in.opcode;
            r_key <= i_in.value;
        end
        if (r_state == S_UPD) begin
            if (r_op == sli_pkg::OP_INSERT) begin
                r_status <= w_full ? sli_pkg::ST_FULL : sli_pkg::ST_DONE;
            end else begin
                r_status <= w_found ? sli_pkg::ST_DONE : sli_pkg::ST_NOT_FOUND;
            end
        end
    end

    // Output register: holds a result until the sink takes it
    assign w_count_ext = {{sli_pkg::COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_status   <= r_status;
            r_out_count    <= w_count_ext[sli_pkg::COUNT_W-1:0];
            r_out_sm_valid <= w_valid[0];
            r_out_sm_value <= w_valid[0] ? w_val[0] : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.entry_count    = r_out_count;
    assign o_out.smallest_valid = r_out_sm_valid;
    assign o_out.smallest_value = r_out_sm_value;

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_hit))
        else $error("more than one cell claims the first match");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_count) == $countones(w_valid)))
        else $error("entry count disagrees with valid cells");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("valid cells not packed from the head");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count beyond capacity");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && (r_op == sli_pkg::OP_INSERT) && w_full)
        |=> $stable(r_count))
        else $error("dropped insert changed the count");

endmodule

// ===== tb/sv/sorted_list_insert_delete_tb.sv =====
`timescale 1ns / 100ps

module sorted_list_insert_delete_tb;
    import sli_pkg::*;

    typedef struct packed {
        logic               opcode;
        logic [VALUE_W-1:0] value;
    } t_list_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic                smallest_valid;
        logic [VALUE_W-1:0]  smallest_value;
    } t_list_result;

    localparam int IDLE_PCT      = 36;
    localparam int RANDOM_ITEMS  = 1625;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 20;
    // Item window in which neither side idles
    localparam int CALM_FIRST    = 700;
    localparam int CALM_LAST     = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sli_in_if  in_ch ();
    sli_out_if out_ch ();

    sorted_list_insert_delete u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the sorted store, ascending from entry 0
    logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
    int                        shadow_count;

    t_list_op     pending_ops[$];
    t_list_result expected_results[$];

    int  total_items;
    int  items_sent;
    int  results_checked;
    int  error_count;
    int  stall_cycles;
    int  insert_count;
    int  delete_count;
    int  full_drops;
    int  not_found_count;
    int  peak_count;
    logic in_taken;
    logic calm;

    assign calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);

    // Apply one item to the shadow store and return the result it should give.
    function automatic t_list_result apply_list_op(input t_list_op op);
        t_list_result              res;
        logic signed [VALUE_W-1:0] key;
        int                        slot;
        int                        j;
        key        = $signed(op.value);
        res.status = ST_DONE;
        // Find the first entry not less than the key
        slot = 0;
        while (slot < shadow_count && shadow_list[slot] < key) slot++;
        if (op.opcode == OP_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Open the slot ahead of any equal entries
                for (j = shadow_count; j > slot; j--) shadow_list[j] = shadow_list[j-1];
                shadow_list[slot] = key;
                shadow_count++;
            end
        end else begin
            // Exact match only: a larger entry at the slot stays put
            if (shadow_count == 0 || slot >= shadow_count || shadow_list[slot] != key) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (j = slot; j + 1 < shadow_count; j++) shadow_list[j] = shadow_list[j+1];
                shadow_count--;
            end
        end
        res.entry_count    = shadow_count[COUNT_W-1:0];
        res.smallest_valid = (shadow_count > 0);
        res.smallest_value = (shadow_count > 0) ? shadow_list[0] : '0;
        return res;
    endfunction

    // Record accepted input items, predict their results, and watch for a hang.
    always @(posedge i_clk) begin
        t_list_result res;
        t_list_op     op;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                op.opcode = in_ch.opcode;
                op.value  = in_ch.value;
                res = apply_list_op(op);
                expected_results.push_back(res);
                items_sent <= items_sent + 1;
                if (op.opcode == OP_INSERT) insert_count <= insert_count + 1;
                else                        delete_count <= delete_count + 1;
                if (res.status == ST_FULL)      full_drops      <= full_drops + 1;
                if (res.status == ST_NOT_FOUND) not_found_count <= not_found_count + 1;
                if (shadow_count > peak_count)  peak_count      <= shadow_count;
            end
            // Reset the hang counter on any handshake at either end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("no handshake for %0d cycles", STALL_LIMIT);
                $display("sorted_list_insert_delete_tb: errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Driver: hold an item until it is taken, then advance or idle at random.
    always @(negedge i_clk) begin
        t_list_op nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_ops.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.opcode <= nxt.opcode;
                in_ch.value  <= nxt.value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: stall at random, except inside the calm window.
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: compare every taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: status %0d count %0d",
                       out_ch.status, out_ch.entry_count);
                error_count = error_count + 1;
            end else begin
                exp_res = expected_results.pop_front();
                results_checked <= results_checked + 1;
                if (out_ch.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
                    error_count = error_count + 1;
                end
                if (out_ch.entry_count !== exp_res.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_res.entry_count, out_ch.entry_count);
                    error_count = error_count + 1;
                end
                if (out_ch.smallest_valid !== exp_res.smallest_valid) begin
                    $error("smallest_valid: expected %0d, got %0d",
                           exp_res.smallest_valid, out_ch.smallest_valid);
                    error_count = error_count + 1;
                end
                if (out_ch.smallest_value !== exp_res.smallest_value) begin
                    $error("smallest_value: expected %0d, got %0d",
                           $signed(exp_res.smallest_value), $signed(out_ch.smallest_value));
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial begin
        t_list_op            op;
        logic [VALUE_W-1:0]  value_pool [8];
        int                  insert_pct;
        int                  sel;
        int                  n;

        // Drive every input to a known value before the first edge
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_INSERT;
        in_ch.value     = '0;
        out_ch.ready    = 1'b0;
        shadow_count    = 0;
        items_sent      = 0;
        results_checked = 0;
        error_count     = 0;
        insert_count    = 0;
        delete_count    = 0;
        full_drops      = 0;
        not_found_count = 0;
        peak_count      = 0;

        // Directed part: delete on an empty store
        pending_ops.push_back({OP_DELETE, 32'h0000_0000});
        // Extremes, zero and minus one
        pending_ops.push_back({OP_INSERT, 32'h7FFF_FFFF});
        pending_ops.push_back({OP_INSERT, 32'h8000_0000});
        pending_ops.push_back({OP_INSERT, 32'h0000_0000});
        pending_ops.push_back({OP_INSERT, 32'hFFFF_FFFF});
        // Equal values, then a miss with a larger entry stored, then remove one equal
        pending_ops.push_back({OP_INSERT, 32'd5});
        pending_ops.push_back({OP_INSERT, 32'd5});
        pending_ops.push_back({OP_DELETE, 32'd6});
        pending_ops.push_back({OP_DELETE, 32'd5});
        // Remove the smallest entry so the reported minimum moves
        pending_ops.push_back({OP_DELETE, 32'h8000_0000});
        // Fill the store to capacity with alternating bit patterns and other values
        pending_ops.push_back({OP_INSERT, 32'h5555_5555});
        pending_ops.push_back({OP_INSERT, 32'hAAAA_AAAA});
        pending_ops.push_back({OP_INSERT, 32'h8000_0000});
        pending_ops.push_back({OP_INSERT, 32'h7FFF_FFFF});
        pending_ops.push_back({OP_INSERT, 32'h0000_0001});
        pending_ops.push_back({OP_INSERT, 32'hFFFF_FFFE});
        pending_ops.push_back({OP_INSERT, 32'h0F0F_0F0F});
        pending_ops.push_back({OP_INSERT, 32'hF0F0_F0F0});
        pending_ops.push_back({OP_INSERT, 32'd5});
        pending_ops.push_back({OP_INSERT, 32'd5});
        pending_ops.push_back({OP_INSERT, 32'h1234_5678});
        pending_ops.push_back({OP_INSERT, 32'hEDCB_A987});
        // Insert into a full store, then make room and miss once more
        pending_ops.push_back({OP_INSERT, 32'd42});
        pending_ops.push_back({OP_DELETE, 32'h7FFF_FFFF});
        pending_ops.push_back({OP_DELETE, 32'd42});

        // Small pool of values so deletes find matches often
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (n = 4; n < 8; n++) value_pool[n] = $urandom;

        // Random part: phases that fill, drain and hover, so full and empty recur
        insert_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ((n / 100) % 3)
                    0:       insert_pct = 75;
                    1:       insert_pct = 25;
                    default: insert_pct = 50;
                endcase
            end
            op.opcode = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
            sel = $urandom_range(9);
            if (sel < 6)      op.value = value_pool[$urandom_range(7)];
            else if (sel < 8) op.value = $signed($urandom_range(8)) - 4;
            else              op.value = $urandom;
            pending_ops.push_back(op);
        end
        total_items = pending_ops.size();

        // Release reset once, on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is taken and every result has come back
        while (items_sent != total_items || expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d items (%0d inserts, %0d deletes), checked %0d results",
                 items_sent, insert_count, delete_count, results_checked);
        $display("full-store drops %0d, not-found deletes %0d, peak entry count %0d",
                 full_drops, not_found_count, peak_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("sorted_list_insert_delete_tb: clean");
        end else begin
            $display("sorted_list_insert_delete_tb: errors");
        end
        $finish;
    end

endmodule
